[rtl/core/slcfp_pkg.sv]
// Package for the start-of-frame / length / checksum frame parser.
// Holds sizes, phase and status codes, register indexes and the
// command and status structs between controller and datapath. No dependencies.
package slcfp_pkg;

  localparam int PAYLOAD_DEPTH = 16;
  localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);
  localparam int IDX_W         = $clog2(PAYLOAD_DEPTH + 1);
  localparam int KW            = 4;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PING         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GET_STATUS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK          = 3'd6;

  localparam logic [7:0] LEN_SET_SPEED = 8'd4;
  localparam logic [7:0] LEN_ACK       = 8'd2;
  localparam logic [7:0] LEN_EMPTY     = 8'd0;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_CMD,
    PH_LEN,
    PH_PAYLOAD,
    PH_CHECK,
    PH_EMIT_WAIT,
    PH_EMIT_CMD
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_BAD_SUM = 2'd3
  } status_t;

  typedef struct packed {
    logic clear;
    logic tick;
    logic byte_in;
    logic take_cmd;
    logic take_len;
    logic take_payload;
    logic report_len_err;
    logic report_check;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic start_eq;
    logic len_too_long;
    logic len_zero;
    logic payload_done;
    logic sum_match;
    logic idle_expire;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/slcfp_if.sv]
// Valid/ready channel interfaces for the frame parser: input items
// and result items. No dependencies.
interface slcfp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface slcfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_cmd;
  logic [7:0] frame_length;
  logic [1:0] frame_status;
  logic       has_data;
  logic [7:0] data_byte;
  logic [3:0] data_index;
  logic       last;

  modport source (output valid, output frame_cmd, output frame_length, output frame_status,
                  output has_data, output data_byte, output data_index, output last,
                  input ready);
  modport sink (input valid, input frame_cmd, input frame_length, input frame_status,
                input has_data, input data_byte, input data_index, input last,
                output ready);
endinterface

[rtl/core/slcfp_ctrl.sv]
// Parse and report sequencer of the frame parser.
// Depends on slcfp_pkg for the phase enum and the command and status structs.
module slcfp_ctrl
  import slcfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  phase_t phase, phase_next;
  logic   accept, is_byte, is_tick, emitting;

  assign emitting = (phase == PH_EMIT_WAIT) || (phase == PH_EMIT_CMD);
  assign in_ready = !emitting;
  assign accept   = in_valid && in_ready;
  assign is_byte  = accept && !in_op;
  assign is_tick  = accept && in_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_WAIT: begin
        if (is_byte && stat.start_eq) phase_next = PH_CMD;
      end
      PH_CMD: begin
        if (is_byte) phase_next = PH_LEN;
        else if (is_tick && stat.idle_expire) phase_next = PH_WAIT;
      end
      PH_LEN: begin
        if (is_byte) begin
          if (stat.len_too_long) phase_next = stat.start_eq ? PH_EMIT_CMD : PH_EMIT_WAIT;
          else if (stat.len_zero) phase_next = PH_CHECK;
          else phase_next = PH_PAYLOAD;
        end else if (is_tick && stat.idle_expire) begin
          phase_next = PH_WAIT;
        end
      end
      PH_PAYLOAD: begin
        if (is_byte && stat.payload_done) phase_next = PH_CHECK;
        else if (is_tick && stat.idle_expire) phase_next = PH_WAIT;
      end
      PH_CHECK: begin
        if (is_byte) begin
          phase_next = (!stat.sum_match && stat.start_eq) ? PH_EMIT_CMD : PH_EMIT_WAIT;
        end else if (is_tick && stat.idle_expire) begin
          phase_next = PH_WAIT;
        end
      end
      PH_EMIT_WAIT: begin
        if (stat.out_free && stat.emit_last) phase_next = PH_WAIT;
      end
      PH_EMIT_CMD: begin
        if (stat.out_free && stat.emit_last) phase_next = PH_CMD;
      end
      default: phase_next = PH_WAIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.byte_in = is_byte;
    unique case (phase)
      PH_WAIT: begin
        cmd.clear = is_byte && stat.start_eq;
      end
      PH_CMD: begin
        cmd.take_cmd = is_byte;
        cmd.tick     = is_tick;
        cmd.clear    = is_tick && stat.idle_expire;
      end
      PH_LEN: begin
        cmd.take_len       = is_byte;
        cmd.report_len_err = is_byte && stat.len_too_long;
        cmd.tick           = is_tick;
        cmd.clear          = (is_byte && stat.len_too_long) || (is_tick && stat.idle_expire);
      end
      PH_PAYLOAD: begin
        cmd.take_payload = is_byte;
        cmd.tick         = is_tick;
        cmd.clear        = is_tick && stat.idle_expire;
      end
      PH_CHECK: begin
        cmd.report_check = is_byte;
        cmd.tick         = is_tick;
        cmd.clear        = is_byte || (is_tick && stat.idle_expire);
      end
      PH_EMIT_WAIT, PH_EMIT_CMD: begin
        cmd.emit = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/core/slcfp_dp.sv]
// Datapath of the frame parser: configuration registers, frame registers,
// payload memory, report registers and the result output register.
// Depends on slcfp_pkg and the slcfp_out_if interface.
module slcfp_dp
  import slcfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [7:0]           rx_byte,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  slcfp_out_if.source          out_ch
);

  logic [7:0] start_byte, idle_timeout_ticks;
  logic [7:0] code_set_speed, code_stop, code_ping, code_get_status, code_ack;

  logic [7:0]       held_cmd, held_len, running_sum, idle_count, idle_inc;
  logic [IDX_W-1:0] byte_index, index_inc;

  logic [7:0] payload_store [PAYLOAD_DEPTH];
  logic [7:0] mem_q;
  logic [KW-1:0] rd_addr;

  logic [7:0]    rep_cmd, rep_len;
  status_t       rep_status;
  logic          rep_data;
  logic [KW-1:0] rep_last, k;

  logic    out_valid;
  status_t cmd_status;

  function automatic status_t check_command(input logic [7:0] c, input logic [7:0] len);
    status_t s;
    if (c == code_set_speed) s = (len == LEN_SET_SPEED) ? ST_OK : ST_BAD_LEN;
    else if (c == code_stop || c == code_ping || c == code_get_status)
      s = (len == LEN_EMPTY) ? ST_OK : ST_BAD_LEN;
    else if (c == code_ack) s = (len == LEN_ACK) ? ST_OK : ST_BAD_LEN;
    else s = ST_UNKNOWN;
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte         <= 8'd170;
      idle_timeout_ticks <= 8'd50;
      code_set_speed     <= 8'd1;
      code_stop          <= 8'd2;
      code_ping          <= 8'd3;
      code_get_status    <= 8'd4;
      code_ack           <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE:   start_byte         <= cfg_data;
        CFG_IDLE_TIMEOUT: idle_timeout_ticks <= cfg_data;
        CFG_SET_SPEED:    code_set_speed     <= cfg_data;
        CFG_STOP:         code_stop          <= cfg_data;
        CFG_PING:         code_ping          <= cfg_data;
        CFG_GET_STATUS:   code_get_status    <= cfg_data;
        CFG_ACK:          code_ack           <= cfg_data;
        default: ;
      endcase
    end
  end

  assign index_inc  = byte_index + IDX_W'(1);
  assign idle_inc   = (idle_count < idle_timeout_ticks) ? idle_count + 8'd1 : idle_count;
  assign cmd_status = (rx_byte == running_sum) ? check_command(held_cmd, held_len) : ST_BAD_SUM;

  assign stat.start_eq     = rx_byte == start_byte;
  assign stat.len_too_long = rx_byte > 8'(PAYLOAD_DEPTH);
  assign stat.len_zero     = rx_byte == 8'd0;
  assign stat.payload_done = {{(8 - IDX_W){1'b0}}, index_inc} >= held_len;
  assign stat.sum_match    = rx_byte == running_sum;
  assign stat.idle_expire  = idle_inc >= idle_timeout_ticks;
  assign stat.emit_last    = k == rep_last;
  assign stat.out_free     = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cmd    <= '0;
      held_len    <= '0;
      byte_index  <= '0;
      running_sum <= '0;
      idle_count  <= '0;
    end else if (cmd.clear) begin
      held_len    <= '0;
      byte_index  <= '0;
      running_sum <= '0;
      idle_count  <= '0;
    end else begin
      if (cmd.byte_in) idle_count <= '0;
      else if (cmd.tick) idle_count <= idle_inc;
      if (cmd.take_cmd) begin
        held_cmd    <= rx_byte;
        running_sum <= rx_byte;
      end
      if (cmd.take_len) begin
        held_len    <= rx_byte;
        running_sum <= running_sum + rx_byte;
        byte_index  <= '0;
      end
      if (cmd.take_payload) begin
        byte_index  <= index_inc;
        running_sum <= running_sum + rx_byte;
      end
    end
  end

  always_comb begin
    if (cmd.report_check || cmd.report_len_err) rd_addr = '0;
    else if (cmd.emit) rd_addr = k + KW'(1);
    else rd_addr = k;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_payload) payload_store[byte_index[PAYLOAD_AW-1:0]] <= rx_byte;
    mem_q <= payload_store[rd_addr[PAYLOAD_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.report_len_err) begin
      rep_cmd    <= held_cmd;
      rep_len    <= rx_byte;
      rep_status <= ST_BAD_LEN;
      rep_data   <= 1'b0;
      rep_last   <= '0;
      k          <= '0;
    end else if (cmd.report_check) begin
      rep_cmd    <= held_cmd;
      rep_len    <= held_len;
      rep_status <= cmd_status;
      rep_data   <= held_len != 8'd0;
      rep_last   <= (held_len == 8'd0) ? '0 : KW'(held_len - 8'd1);
      k          <= '0;
    end else if (cmd.emit) begin
      k <= k + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch.frame_cmd    <= rep_cmd;
      out_ch.frame_length <= rep_len;
      out_ch.frame_status <= rep_status;
      out_ch.has_data     <= rep_data;
      out_ch.data_byte    <= rep_data ? mem_q : 8'd0;
      out_ch.data_index   <= rep_data ? k : '0;
      out_ch.last         <= k == rep_last;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

[rtl/core/sof_len_checksum_frame_parser.sv]
// Top level of the start-of-frame / length / checksum frame parser.
// Depends on slcfp_pkg, slcfp_if.sv, slcfp_ctrl and slcfp_dp.
//
//   Channel   Direction  Contents
//   in_ch     in         op, rx_byte (byte or idle tick)
//   out_ch    out        frame_cmd, frame_length, frame_status, has_data,
//                        data_byte, data_index, last
//   cfg_*     in         write enable, register index, 8-bit data
//
// Bytes and ticks are accepted except during a report. A report of n results
// (one per payload byte, at least one) holds the input while the sequencer
// steps the payload memory read port once per result; a stall on out_ch
// stretches the hold. Reset is synchronous and restores register defaults.
module sof_len_checksum_frame_parser
  import slcfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  slcfp_in_if.sink             in_ch,
  slcfp_out_if.source          out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ready;

  assign in_ch.ready = ready;

  slcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slcfp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (in_ch.rx_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_ch    (out_ch)
  );

endmodule

[verif/slcfp_report_checker.sv]
`timescale 1ns / 1ps
// Checker for the frame parser: watches the config port and both channels,
// predicts every report beat and compares it with the DUT output.
// Depends on slcfp_pkg.
module slcfp_report_checker
  import slcfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_op,
  input  logic [7:0]           in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           out_frame_cmd,
  input  logic [7:0]           out_frame_length,
  input  logic [1:0]           out_frame_status,
  input  logic                 out_has_data,
  input  logic [7:0]           out_data_byte,
  input  logic [3:0]           out_data_index,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] len;
    status_t    status;
    logic       has_data;
    logic [7:0] data;
    logic [3:0] index;
    logic       is_last;
  } report_beat_t;

  logic [7:0] start_r;
  logic [7:0] timeout_r;
  logic [7:0] code_speed_r;
  logic [7:0] code_stop_r;
  logic [7:0] code_ping_r;
  logic [7:0] code_status_r;
  logic [7:0] code_ack_r;

  phase_t     phase;
  logic [7:0] cmd_h;
  logic [7:0] len_h;
  logic [4:0] idx_h;
  logic [7:0] sum_h;
  logic [7:0] idle_cnt;
  logic [7:0] payload_mem [PAYLOAD_DEPTH];

  report_beat_t expected_beats[$];
  int mismatches = 0;
  int queued = 0;

  assign fail_count = mismatches;
  assign pending    = queued;

  task automatic clear_frame(input logic open);
    phase    = open ? PH_CMD : PH_WAIT;
    len_h    = '0;
    idx_h    = '0;
    sum_h    = '0;
    idle_cnt = '0;
  endtask

  task automatic queue_report(input logic [7:0] c, input logic [7:0] l, input status_t st,
                              input int shown);
    report_beat_t beat;
    int n;
    int k;
    if (shown > 16) shown = 16;
    n = (shown == 0) ? 1 : shown;
    for (k = 0; k < n; k++) begin
      beat.cmd      = c;
      beat.len      = l;
      beat.status   = st;
      beat.has_data = (shown != 0);
      beat.data     = (shown != 0) ? payload_mem[k % PAYLOAD_DEPTH] : 8'h00;
      beat.index    = (shown != 0) ? 4'(k) : 4'h0;
      beat.is_last  = (k + 1 == n);
      expected_beats.push_back(beat);
    end
  endtask

  task automatic take_item(input logic op, input logic [7:0] b);
    status_t st;
    if (op) begin
      if (phase != PH_WAIT) begin
        if (idle_cnt < timeout_r) idle_cnt = idle_cnt + 8'd1;
        if (idle_cnt >= timeout_r) clear_frame(1'b0);
      end
    end else begin
      idle_cnt = '0;
      case (phase)
        PH_WAIT: begin
          if (b == start_r) clear_frame(1'b1);
        end
        PH_CMD: begin
          cmd_h = b;
          sum_h = b;
          phase = PH_LEN;
        end
        PH_LEN: begin
          len_h = b;
          sum_h = sum_h + b;
          if (b > PAYLOAD_DEPTH) begin
            queue_report(cmd_h, b, ST_BAD_LEN, 0);
            clear_frame(b == start_r);
          end else if (b == LEN_EMPTY) begin
            phase = PH_CHECK;
          end else begin
            idx_h = '0;
            phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          payload_mem[idx_h[PAYLOAD_AW-1:0]] = b;
          idx_h = idx_h + 5'd1;
          sum_h = sum_h + b;
          if (idx_h >= len_h) phase = PH_CHECK;
        end
        PH_CHECK: begin
          if (b == sum_h) begin
            if (cmd_h == code_speed_r) begin
              st = (len_h == LEN_SET_SPEED) ? ST_OK : ST_BAD_LEN;
            end else if (cmd_h == code_stop_r || cmd_h == code_ping_r ||
                         cmd_h == code_status_r) begin
              st = (len_h == LEN_EMPTY) ? ST_OK : ST_BAD_LEN;
            end else if (cmd_h == code_ack_r) begin
              st = (len_h == LEN_ACK) ? ST_OK : ST_BAD_LEN;
            end else begin
              st = ST_UNKNOWN;
            end
            queue_report(cmd_h, len_h, st, int'(len_h));
            clear_frame(1'b0);
          end else begin
            queue_report(cmd_h, len_h, ST_BAD_SUM, int'(len_h));
            clear_frame(b == start_r);
          end
        end
        default: clear_frame(1'b0);
      endcase
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    report_beat_t want;
    if (rst) begin
      start_r       = 8'd170;
      timeout_r     = 8'd50;
      code_speed_r  = 8'd1;
      code_stop_r   = 8'd2;
      code_ping_r   = 8'd3;
      code_status_r = 8'd4;
      code_ack_r    = 8'd5;
      cmd_h         = '0;
      foreach (payload_mem[i]) payload_mem[i] = '0;
      clear_frame(1'b0);
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_BYTE:   start_r       = cfg_data;
          CFG_IDLE_TIMEOUT: timeout_r     = cfg_data;
          CFG_SET_SPEED:    code_speed_r  = cfg_data;
          CFG_STOP:         code_stop_r   = cfg_data;
          CFG_PING:         code_ping_r   = cfg_data;
          CFG_GET_STATUS:   code_status_r = cfg_data;
          CFG_ACK:          code_ack_r    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_item(in_op, in_rx_byte);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("Unexpected result transaction: frame_cmd %0h, frame_length %0h",
                 out_frame_cmd, out_frame_length);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("frame_cmd", want.cmd, out_frame_cmd);
          check_field("frame_length", want.len, out_frame_length);
          check_field("frame_status", int'(want.status), out_frame_status);
          check_field("has_data", want.has_data, out_has_data);
          check_field("data_byte", want.data, out_data_byte);
          check_field("data_index", want.index, out_data_index);
          check_field("last", want.is_last, out_last);
        end
      end
    end
    queued = expected_beats.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the frame parser: clock, reset, byte and tick stimulus,
// config phases and the verdict. Depends on slcfp_pkg, slcfp_if.sv and
// slcfp_report_checker.
module tb;
  import slcfp_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  slcfp_in_if  in_ch ();
  slcfp_out_if out_ch ();

  int         mismatches;
  int         pending;
  int         stall_cycles = 0;
  int         frame_items = 0;
  bit         quiet = 1'b0;
  logic [7:0] cur_start;
  logic [7:0] cur_timeout;
  logic [7:0] cur_codes [5];

  // Set-speed ok, too long, too long on the start byte with restart, bad
  // checksum on the start byte with restart, and an unknown command.
  logic [7:0] directed_bytes [26] = '{
    8'hAA, 8'h01, 8'h04, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h03,
    8'hAA, 8'h05, 8'h11,
    8'hAA, 8'h07, 8'hAA, 8'h02, 8'h00, 8'h02,
    8'hAA, 8'h05, 8'h02, 8'h11, 8'h22, 8'hAA,
    8'h09, 8'h00, 8'h09
  };

  sof_len_checksum_frame_parser dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  slcfp_report_checker report_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_op            (in_ch.op),
    .in_rx_byte       (in_ch.rx_byte),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_frame_cmd    (out_ch.frame_cmd),
    .out_frame_length (out_ch.frame_length),
    .out_frame_status (out_ch.frame_status),
    .out_has_data     (out_ch.has_data),
    .out_data_byte    (out_ch.data_byte),
    .out_data_index   (out_ch.data_index),
    .out_last         (out_ch.last),
    .fail_count       (mismatches),
    .pending          (pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Ticks inside an open frame; mostly short of the timeout, now and then past it when the timeout is at most 20.
  task automatic tick_gap();
    int k;
    k = 0;
    if ($urandom_range(0, 9) == 0) begin
      if (cur_timeout <= 20 && $urandom_range(0, 7) == 0) begin
        k = int'(cur_timeout) + $urandom_range(0, 2);
      end else if (cur_timeout > 1) begin
        k = $urandom_range(1, (cur_timeout > 20) ? 20 : int'(cur_timeout) - 1);
      end
    end
    repeat (k) begin
      send_item(1'b1, 8'($urandom));
      frame_items++;
    end
  endtask

  task automatic put_frame_byte(input logic [7:0] b);
    tick_gap();
    send_item(1'b0, b);
    frame_items++;
  endtask

  task automatic send_frame();
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    int pick;
    pick = $urandom_range(0, 6);
    cmd = (pick < 5) ? cur_codes[pick] : 8'($urandom);
    if (cmd == cur_codes[0]) begin
      len = LEN_SET_SPEED;
    end else if (cmd == cur_codes[1] || cmd == cur_codes[2] || cmd == cur_codes[3]) begin
      len = LEN_EMPTY;
    end else if (cmd == cur_codes[4]) begin
      len = LEN_ACK;
    end else begin
      len = 8'($urandom_range(0, PAYLOAD_DEPTH));
    end
    pick = $urandom_range(0, 9);
    if (pick == 9) begin
      len = ($urandom_range(0, 3) == 0) ? cur_start : 8'($urandom_range(PAYLOAD_DEPTH + 1, 255));
    end else if (pick >= 6) begin
      len = 8'($urandom_range(0, PAYLOAD_DEPTH));
    end
    send_item(1'b0, cur_start);
    frame_items++;
    put_frame_byte(cmd);
    put_frame_byte(len);
    if (len <= PAYLOAD_DEPTH) begin
      sum = cmd + len;
      repeat (len) begin
        b = 8'($urandom);
        sum = sum + b;
        put_frame_byte(b);
      end
      if ($urandom_range(0, 6) == 0) begin
        if (cur_start != sum && $urandom_range(0, 1) == 1) begin
          sum = cur_start;
        end else begin
          sum = sum ^ 8'($urandom_range(1, 255));
        end
      end
      put_frame_byte(sum);
    end
  endtask

  task automatic run_random(input int budget);
    int goal;
    goal = frame_items + budget;
    while (frame_items < goal) begin
      case ($urandom_range(0, 9))
        0:       send_item(1'b1, 8'($urandom));
        1:       send_item(1'b0, 8'($urandom));
        default: send_frame();
      endcase
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] sb, input logic [7:0] to, input logic [7:0] sp,
                            input logic [7:0] st, input logic [7:0] pg, input logic [7:0] gs,
                            input logic [7:0] ak);
    write_reg(CFG_START_BYTE, sb);
    write_reg(CFG_IDLE_TIMEOUT, to);
    write_reg(CFG_SET_SPEED, sp);
    write_reg(CFG_STOP, st);
    write_reg(CFG_PING, pg);
    write_reg(CFG_GET_STATUS, gs);
    write_reg(CFG_ACK, ak);
    cfg_we <= 1'b0;
    cur_start   = sb;
    cur_timeout = to;
    cur_codes   = '{sp, st, pg, gs, ak};
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.op      = 1'b0;
    in_ch.rx_byte = 8'h00;
    cur_start     = 8'd170;
    cur_timeout   = 8'd50;
    cur_codes     = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(1'b1, 8'h5C);
    foreach (directed_bytes[i]) send_item(1'b0, directed_bytes[i]);
    run_random(110);

    drain();
    set_config(8'h00, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01);
    run_random(110);

    // All codes equal, so the set-speed check must win; no idling here.
    drain();
    set_config(8'hFF, 8'hFF, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A);
    quiet = 1'b1;
    run_random(110);
    quiet = 1'b0;

    drain();
    set_config(8'($urandom), 8'($urandom_range(1, 8)), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom));
    run_random(120);

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
